### hw/rtl/ppc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants for the pool pressure classifier.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int unsigned ValW = 64;
  localparam int unsigned ThrW = 14;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    LEVEL_CLEAR    = 2'd0,
    LEVEL_ELEVATED = 2'd1,
    LEVEL_HIGH     = 2'd2,
    LEVEL_CRITICAL = 2'd3
  } level_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ELEVATED = 2'd0,
    REG_HIGH     = 2'd1,
    REG_CRITICAL = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ValW-1:0] used_units;
    logic [ValW-1:0] usable_units;
    logic            overcommit_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      pressure_level;
    logic [ThrW-1:0] utilization;
    logic [ThrW-1:0] binding_threshold;
    logic            overcommit_echo;
  } out_item_t;

  typedef struct packed {
    logic [ThrW-1:0] elevated;
    logic [ThrW-1:0] high;
    logic [ThrW-1:0] critical;
  } thr_set_t;

endpackage
`default_nettype wire

### hw/rtl/pool_pressure_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pool_pressure_classifier_core
// Classifies pool pressure from used and usable counts in basis points.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the pipe advances, and each gives one
// result: the pipelined restoring divider computes one quotient bit per stage,
// and the output register then holds the result. The three threshold compares
// run in parallel three-stage multiply pipelines and are delayed to line up
// with the divider. A full output register decouples the result; the whole
// pipe advances whenever the output slot is empty or being taken, and holds
// while a result waits.
module pool_pressure_classifier_core #(
  parameter int unsigned BASIS_SCALE = 10000
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ppc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ppc_pkg::ThrW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire ppc_pkg::in_item_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output ppc_pkg::out_item_t                out_data_o
);
  localparam int unsigned SclW = $clog2(BASIS_SCALE + 1);
  localparam int unsigned QW   = SclW;
  localparam int unsigned NumW = ppc_pkg::ValW + SclW;
  localparam int unsigned CmpLat = 3;

  ppc_pkg::thr_set_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.elevated <= 14'd7000;
      thr_q.high     <= 14'd8500;
      thr_q.critical <= 14'd9500;
    end else if (cfg_we_i) begin
      case (ppc_pkg::reg_idx_e'(cfg_idx_i))
        ppc_pkg::REG_ELEVATED: thr_q.elevated <= cfg_data_i;
        ppc_pkg::REG_HIGH:     thr_q.high     <= cfg_data_i;
        ppc_pkg::REG_CRITICAL: thr_q.critical <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  logic adv;
  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;

  // Front stage: product, overflow and special-case flags.
  logic [NumW-1:0] prod;
  logic            ovf, zero_den, idle_pool, sat;
  assign prod      = {{SclW{1'b0}}, in_data_i.used_units} * NumW'(BASIS_SCALE);
  assign ovf       = |prod[NumW-1:ppc_pkg::ValW];
  assign zero_den  = in_data_i.usable_units == '0;
  assign idle_pool = (in_data_i.used_units == '0) & ~in_data_i.overcommit_flag;
  assign sat       = in_data_i.used_units >= in_data_i.usable_units;

  // Saturation: quotient >= scale when used >= usable; clamp numerator so
  // the divider quotient fits, and force scale when saturated.
  logic [NumW-1:0] num_in;
  assign num_in = (ovf | sat) ? '0 : prod;

  localparam int unsigned SideW = 5;
  logic [SideW-1:0] side_in, side_out;
  assign side_in = {sat, in_data_i.overcommit_flag, ovf, zero_den, idle_pool};

  logic            div_vld;
  logic [QW-1:0]   quot;
  logic            div_valid_in;
  assign div_valid_in = in_valid_i;

  // Saturated items send a zero numerator, so the quotient always fits QW
  // bits (scale < 2^QW).
  ppc_divider #(
    .NumW(NumW), .DenW(ppc_pkg::ValW), .QW(QW), .SideW(SideW)
  ) u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(div_valid_in),
    .num_i(num_in), .den_i(in_data_i.usable_units), .side_i(side_in),
    .valid_o(div_vld), .quot_o(quot), .side_o(side_out)
  );

  // Compares: capture thresholds at entry, delay results to divider output.
  logic [2:0] reach;
  ppc_compare #(.Scale(BASIS_SCALE)) u_cmp_e (
    .clk_i, .en_i(adv), .used_i(in_data_i.used_units),
    .usable_i(in_data_i.usable_units), .thr_i(thr_q.elevated), .reach_o(reach[0]));
  ppc_compare #(.Scale(BASIS_SCALE)) u_cmp_h (
    .clk_i, .en_i(adv), .used_i(in_data_i.used_units),
    .usable_i(in_data_i.usable_units), .thr_i(thr_q.high), .reach_o(reach[1]));
  ppc_compare #(.Scale(BASIS_SCALE)) u_cmp_c (
    .clk_i, .en_i(adv), .used_i(in_data_i.used_units),
    .usable_i(in_data_i.usable_units), .thr_i(thr_q.critical), .reach_o(reach[2]));

  localparam int unsigned DlyN = QW - CmpLat;
  logic [2:0]                  rch_q [DlyN+1];
  ppc_pkg::thr_set_t           tdl_q [QW+1];
  assign rch_q[0] = reach;
  assign tdl_q[0] = thr_q;
  for (genvar i = 0; i < DlyN; i++) begin : g_rdly
    always_ff @(posedge clk_i) begin
      if (adv) rch_q[i+1] <= rch_q[i];
    end
  end
  for (genvar i = 0; i < QW; i++) begin : g_tdly
    always_ff @(posedge clk_i) begin
      if (adv) tdl_q[i+1] <= tdl_q[i];
    end
  end

  ppc_pkg::out_item_t res_d, out_q;
  logic [2:0]        rf;
  ppc_pkg::thr_set_t tf;
  always_comb begin
    rf = rch_q[DlyN];
    tf = tdl_q[QW];
    res_d.overcommit_echo = side_out[3];
    if (side_out[1]) begin
      if (side_out[0]) begin
        res_d.pressure_level    = ppc_pkg::LEVEL_CLEAR;
        res_d.utilization       = '0;
        res_d.binding_threshold = '0;
      end else begin
        res_d.pressure_level    = ppc_pkg::LEVEL_CRITICAL;
        res_d.utilization       = ppc_pkg::ThrW'(BASIS_SCALE);
        res_d.binding_threshold = tf.critical;
      end
    end else begin
      if (side_out[2] || side_out[4] || quot >= QW'(BASIS_SCALE)) begin
        res_d.utilization = ppc_pkg::ThrW'(BASIS_SCALE);
      end else begin
        res_d.utilization = ppc_pkg::ThrW'(quot);
      end
      if (rf[2]) begin
        res_d.pressure_level = ppc_pkg::LEVEL_CRITICAL;
        res_d.binding_threshold = tf.critical;
      end else if (rf[1]) begin
        res_d.pressure_level = ppc_pkg::LEVEL_HIGH;
        res_d.binding_threshold = tf.high;
      end else if (rf[0]) begin
        res_d.pressure_level = ppc_pkg::LEVEL_ELEVATED;
        res_d.binding_threshold = tf.elevated;
      end else begin
        res_d.pressure_level = ppc_pkg::LEVEL_CLEAR;
        res_d.binding_threshold = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### hw/rtl/ppc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_divider
// Pipelined restoring divider: one quotient bit per stage, QW stages, with a
// stall enable shared by all stages. Sideband data travels along.
// ----------------------------------------------------------------------------
module ppc_divider #(
  parameter int unsigned NumW  = 78,
  parameter int unsigned DenW  = 64,
  parameter int unsigned QW    = 14,
  parameter int unsigned SideW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [DenW-1:0]  den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [QW-1:0]         quot_o,
  output logic [SideW-1:0]      side_o
);
  // Numerator is assumed below den << QW, so the quotient fits QW bits.
  localparam int unsigned RemW = DenW + 1;

  logic [QW:0]              vld_q;
  logic [NumW-1:0]          num_q  [QW+1];
  logic [DenW-1:0]          den_q  [QW+1];
  logic [RemW-1:0]          rem_q  [QW+1];
  logic [QW-1:0]            quo_q  [QW+1];
  logic [SideW-1:0]         side_q [QW+1];

  always_comb begin
    vld_q[0]  = valid_i;
    num_q[0]  = num_i;
    den_q[0]  = den_i;
    rem_q[0]  = '0;
    quo_q[0]  = '0;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    // Bits from QW-1 upward enter the remainder in the first stage.
    localparam int unsigned Shift = QW - 1 - s;
    logic [NumW+RemW-1:0] wide;
    logic [RemW-1:0]      trial;
    logic [RemW:0]        diff;
    logic                 take;
    logic [RemW-1:0]      rem_d;

    always_comb begin
      if (s == 0) begin
        wide  = {{RemW{1'b0}}, num_q[s]} >> Shift;
        trial = wide[RemW-1:0];
      end else begin
        trial = {rem_q[s][RemW-2:0], num_q[s][Shift]};
        wide  = '0;
      end
      diff  = {1'b0, trial} - {2'b0, den_q[s]};
      take  = ~diff[RemW];
      rem_d = take ? diff[RemW-1:0] : trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= num_q[s];
        den_q[s+1]  <= den_q[s];
        rem_q[s+1]  <= rem_d;
        quo_q[s+1]  <= {quo_q[s][QW-2:0], take};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule
`default_nettype wire

### hw/rtl/ppc_compare.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_compare
// Exact compare used*SCALE >= thr*usable in three stages: 32x14 partial
// products, then 78-bit sums (default scale), then the compare.
// ----------------------------------------------------------------------------
module ppc_compare #(
  parameter int unsigned Scale = 10000
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [ppc_pkg::ValW-1:0] used_i,
  input  wire logic [ppc_pkg::ValW-1:0] usable_i,
  input  wire logic [ppc_pkg::ThrW-1:0] thr_i,
  output logic                          reach_o
);
  localparam int unsigned SclW = $clog2(Scale + 1);

  logic [ppc_pkg::ValW+SclW-1:0] lhs_q;
  logic [ppc_pkg::ThrW+31:0]     plo_q, phi_q;
  logic [ppc_pkg::ValW+SclW-1:0] lhs2_q;
  logic [ppc_pkg::ValW+ppc_pkg::ThrW-1:0] rhs_q;
  logic [ppc_pkg::ThrW+31:0]     ulo_q, uhi_q;

  // Stage 1: split products on 32-bit halves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ulo_q <= {ppc_pkg::ThrW'(0), used_i[31:0]} * (ppc_pkg::ThrW+32)'(Scale);
      uhi_q <= {ppc_pkg::ThrW'(0), used_i[63:32]} * (ppc_pkg::ThrW+32)'(Scale);
      plo_q <= {ppc_pkg::ThrW'(0), usable_i[31:0]} * {32'd0, thr_i};
      phi_q <= {ppc_pkg::ThrW'(0), usable_i[63:32]} * {32'd0, thr_i};
    end
  end

  // Stage 2: assemble both sides.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs2_q <= (ppc_pkg::ValW+SclW)'({uhi_q, 32'd0})
              + (ppc_pkg::ValW+SclW)'(ulo_q);
      rhs_q  <= (ppc_pkg::ValW+ppc_pkg::ThrW)'({phi_q, 32'd0})
              + (ppc_pkg::ValW+ppc_pkg::ThrW)'(plo_q);
    end
  end

  // Stage 3: register both sides; the compare follows combinationally.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs_q <= lhs2_q;
    end
  end

  logic [ppc_pkg::ValW+ppc_pkg::ThrW-1:0] rhs3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rhs3_q <= rhs_q;
    end
  end

  assign reach_o = {{(ppc_pkg::ThrW){1'b0}}, lhs_q} >= {{SclW{1'b0}}, rhs3_q};

endmodule
`default_nettype wire

### hw/rtl/ppc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_checker
// Port-level checks on the pool pressure classifier.
// ----------------------------------------------------------------------------
module ppc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire ppc_pkg::out_item_t out_data_o
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o) else $error("ready dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result not held");
  a_util: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.utilization <= 14'd10000) else $error("util range");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pressure_level == ppc_pkg::LEVEL_CLEAR
    |-> out_data_o.binding_threshold == '0) else $error("clear bind");
endmodule

bind pool_pressure_classifier_core ppc_checker u_chk (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
